/* sv/ttda_pkg.sv */
`timescale 1ns / 1ps
package ttda_pkg;

  localparam int DEF_ENTRY_COUNT = 4096;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [14:0] MATE_RST = 15'd32000;
  localparam logic [14:0] DRAW_RST = 15'd0;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW = 8'd1;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_PROBE = 2'd1;
  localparam logic [1:0] KIND_NEWSRCH = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        hash_key;
    logic [15:0]        move_code;
    logic signed [15:0] score_in;
    logic [7:0]         search_depth;
    logic [1:0]         bound_flag;
    logic [7:0]         ply;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        found_move;
    logic signed [15:0] found_score;
    logic [7:0]         found_depth;
    logic [1:0]         found_flag;
    logic [31:0]        hit_total;
    logic [31:0]        miss_total;
  } out_word_t;

  // queued op, score already mate-adjusted
  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        hash_key;
    logic [15:0]        move_code;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [1:0]         flag;
  } qitem_t;

  typedef struct packed {
    logic               valid;
    logic [63:0]        key;
    logic [15:0]        move_code;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [1:0]         flag;
    logic [7:0]         age;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* sv/ttda_front.sv */
`timescale 1ns / 1ps
module ttda_front import ttda_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [14:0]          cfg_data,
  input  fifo_stat_t           q_stat,
  input  logic                 sweeping,
  output logic                 push,
  output qitem_t               push_data
);

  logic [14:0] mate_r, draw_r;
  logic signed [16:0] s_ext, m_ext, d_ext, p_ext, adj;

  assign cfg_ready = 1'b1;
  assign busy      = q_stat.full | sweeping;
  assign push      = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mate_r <= MATE_RST;
      draw_r <= DRAW_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MATE) mate_r <= cfg_data;
      if (cfg_index == CFG_DRAW) draw_r <= cfg_data;
    end
  end

  // |score| in (draw, mate) moves ply toward zero; rest left alone
  always_comb begin
    s_ext = {in_data.score_in[15], in_data.score_in};
    m_ext = {2'b00, mate_r};
    d_ext = {2'b00, draw_r};
    p_ext = {9'd0, in_data.ply};
    adj   = s_ext;
    if (s_ext > -m_ext && s_ext < -d_ext) begin
      adj = s_ext + p_ext;
    end else if (s_ext > d_ext && s_ext < m_ext) begin
      adj = s_ext - p_ext;
    end
  end

  always_comb begin
    push_data.kind      = in_data.kind;
    push_data.hash_key  = in_data.hash_key;
    push_data.move_code = in_data.move_code;
    push_data.score     = adj[15:0];
    push_data.depth     = in_data.search_depth;
    push_data.flag      = in_data.bound_flag;
  end

endmodule

/* sv/ttda_fifo.sv */
`timescale 1ns / 1ps
module ttda_fifo import ttda_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  qitem_t     push_data,
  input  logic       pop,
  output qitem_t     head,
  output fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qitem_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

/* sv/ttda_back.sv */
`timescale 1ns / 1ps
module ttda_back import ttda_pkg::*; #(
  parameter int ENTRY_COUNT = DEF_ENTRY_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  qitem_t     head,
  input  fifo_stat_t q_stat,
  output logic       pop,
  output logic       sweeping,
  output logic       out_valid,
  output out_word_t  out_data
);

  localparam int IDX_W = $clog2(ENTRY_COUNT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  entry_t mem [ENTRY_COUNT];
  entry_t rd_r, wr_data;
  qitem_t cur_r;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] sweep_r, sweep_nxt, rd_idx, wr_idx;
  logic [7:0]       age_r, age_nxt;
  logic [31:0]      hit_r, hit_nxt, miss_r, miss_nxt;
  logic             we, key_eq, slot_hit, do_write;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  assign rd_idx = head.hash_key[IDX_W-1:0];

  // read every cycle at the queue head; used in EXEC
  always_ff @(posedge clk) begin
    if (we) mem[wr_idx] <= wr_data;
    rd_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

  always_comb begin
    key_eq   = (rd_r.key == cur_r.hash_key);
    slot_hit = rd_r.valid & key_eq;
    do_write = ~rd_r.valid | key_eq | (cur_r.depth >= rd_r.depth) | (rd_r.age != age_r);
  end

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    age_nxt       = age_r;
    hit_nxt       = hit_r;
    miss_nxt      = miss_r;
    pop           = 1'b0;
    we            = 1'b0;
    wr_idx        = cur_r.hash_key[IDX_W-1:0];
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    wr_data.valid     = 1'b1;
    wr_data.key       = cur_r.hash_key;
    wr_data.move_code = cur_r.move_code;
    wr_data.score     = cur_r.score;
    wr_data.depth     = cur_r.depth;
    wr_data.flag      = cur_r.flag;
    wr_data.age       = age_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (head.kind)
            KIND_STORE, KIND_PROBE: state_nxt = ST_EXEC;
            KIND_NEWSRCH: age_nxt = age_r + 8'd1;
            KIND_CLEAR: begin
              age_nxt   = '0;
              hit_nxt   = '0;
              miss_nxt  = '0;
              sweep_nxt = '0;
              state_nxt = ST_SWEEP;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        if (cur_r.kind == KIND_STORE) begin
          we = do_write;
        end else begin
          out_valid_nxt = 1'b1;
          if (slot_hit) hit_nxt = hit_r + 32'd1;
          else          miss_nxt = miss_r + 32'd1;
          out_data_nxt.hit         = slot_hit;
          out_data_nxt.found_move  = slot_hit ? rd_r.move_code : '0;
          out_data_nxt.found_score = slot_hit ? rd_r.score : '0;
          out_data_nxt.found_depth = slot_hit ? rd_r.depth : '0;
          out_data_nxt.found_flag  = slot_hit ? rd_r.flag : '0;
          out_data_nxt.hit_total   = hit_nxt;
          out_data_nxt.miss_total  = miss_nxt;
        end
      end
      ST_SWEEP: begin
        we        = 1'b1;
        wr_idx    = sweep_r;
        wr_data   = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == IDX_W'(ENTRY_COUNT - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      age_r       <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      age_r       <= age_nxt;
      hit_r       <= hit_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) out_data_r <= out_data_nxt;
  end

  assign sweeping  = (state_r == ST_SWEEP);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/transposition_table_depth_age.sv */
`timescale 1ns / 1ps
// Direct-mapped transposition table, depth-preferred with age-aware replacement.
// Input: drive in_data and raise start; the word is taken at an edge where busy
//   is low. kind selects store, probe, new search or clear.
// Output: each probe gives one word on out_data, marked by out_valid for one
//   cycle. There is no back-pressure; the receiver must take it then.
// Config: cfg_valid/cfg_ready write mate_score (index 0) or draw_score
//   (index 1); cfg_ready is always high. Write only while the block is idle.
// Timing: a front stage adjusts the score and queues the word (QUEUE_DEPTH
//   deep); the back engine takes one op at a time. Store and probe pop in
//   idle, then compare against the registered slot read in exec; a store
//   may write the slot there (read-modify-write), a probe answers. New search
//   only steps the age; clear sweeps every slot. A probe result passes the
//   queue, the registered read and exec, then is registered onto out_data.
// Reset: age and counters clear, then a sweep zeroes every valid bit; busy
//   stays high during it, and during a clear's sweep.
// busy also rises when the queue is full.
module transposition_table_depth_age import ttda_pkg::*; #(
  parameter int ENTRY_COUNT = DEF_ENTRY_COUNT,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_data,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [14:0]          cfg_data
);

  fifo_stat_t q_stat;
  qitem_t     push_data, head;
  logic       push, pop, sweeping;

  ttda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .sweeping  (sweeping),
    .push      (push),
    .push_data (push_data)
  );

  ttda_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  ttda_back #(.ENTRY_COUNT(ENTRY_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .sweeping  (sweeping),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sv/ttda_checker.sv */
`timescale 1ns / 1ps
module ttda_checker import ttda_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input in_word_t             in_data,
  input logic                 out_valid,
  input out_word_t            out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [14:0]          cfg_data
);

  // table sweep holds off input right after reset
  a_busy_after_rst: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("busy low right after reset");

  // back engine passes through idle between probes
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result words on consecutive cycles");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.found_move == 16'd0 &&
      out_data.found_score == 16'sd0 && out_data.found_depth == 8'd0 &&
      out_data.found_flag == 2'd0)
    else $error("miss word carries slot data");

  a_no_result_in_rst: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind transposition_table_depth_age ttda_checker u_chk (.*);
